### rtl/core/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PH_W   = $clog2(TAB_WIDTH);
  localparam int CELL_W = 16;

  // configuration port
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_TEXT_ATTR = '0;
  localparam logic [7:0] ATTR_RESET = 8'd7;

  // operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // control bytes
  localparam logic [7:0] CH_BELL  = 8'd7;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic wr_char;
    logic wr_blank;
    logic backspace;
    logic col_home;
    logic new_line;
    logic set_bell;
    logic home;
    logic read_cell;
    logic sweep_clr;
    logic sweep_bot;
    logic fill_step;
    logic fill_rst;
    logic copy_step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       at_bottom;
    logic       wrap;
    logic       tab_stop_after;
    logic       tab_stop_now;
    logic       fill_last;
    logic       copy_last;
    logic       out_free;
  } status_t;

endpackage

### rtl/core/tccw_regs.sv
`timescale 1ns / 1ps

module tccw_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tccw_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output logic [7:0]                  text_attr
);
  import tccw_pkg::*;

  logic [7:0] attr_r;
  logic [7:0] attr_nxt;
  logic       hit;

  assign cfg_pready = 1'b1;
  assign hit        = (cfg_paddr[CFG_AW-1:2] == REG_TEXT_ATTR);

  // register write on the access phase
  always_comb begin
    attr_nxt = attr_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit) begin
      attr_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  // read back
  assign cfg_prdata = hit ? {24'd0, attr_r} : 32'd0;
  assign text_attr  = attr_r;

endmodule

### rtl/core/tccw_dp.sv
`timescale 1ns / 1ps

module tccw_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tccw_pkg::cmd_t        cmd,
  output tccw_pkg::status_t     st,
  input  logic [7:0]            text_attr,
  input  logic [1:0]            in_op,
  input  logic [7:0]            in_ch,
  input  logic [4:0]            in_row,
  input  logic [6:0]            in_col,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata
);
  import tccw_pkg::*;

  // screen store
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;

  // latched item
  logic [1:0] op_r;
  logic [7:0] ch_r;
  logic [4:0] rrow_r;
  logic [6:0] rcol_r;
  logic       rd_ok_r, rd_ok_nxt;

  // cursor and flags
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PH_W-1:0]  ph_r, ph_nxt;
  logic             bell_r, bell_nxt;
  logic             scr_r, scr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // output register
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] odata_r, odata_nxt;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] cell_addr;
  logic [PH_W-1:0]   ph_inc;
  logic [PH_W-1:0]   ph_dec;
  logic              wrap;
  logic              at_bottom;
  logic [CELL_W-1:0] blank;
  logic              copy_rd;
  logic [7:0]        o_char, o_attr;

  assign cur_addr  = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign cell_addr = ADDR_W'(rrow_r) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_r);
  assign wrap      = (col_r == COL_W'(COLUMNS - 1));
  assign at_bottom = (row_r == ROW_W'(ROWS - 1));
  assign ph_inc    = (ph_r == PH_W'(TAB_WIDTH - 1)) ? '0 : ph_r + PH_W'(1);
  assign ph_dec    = (ph_r == '0) ? PH_W'(TAB_WIDTH - 1) : ph_r - PH_W'(1);
  assign blank     = {text_attr, CH_SPACE};
  assign copy_rd   = (cnt_r < CNT_W'(CELLS - COLUMNS));

  // status to the controller
  always_comb begin
    st.op             = op_r;
    st.ch             = ch_r;
    st.at_bottom      = at_bottom;
    st.wrap           = wrap;
    st.tab_stop_after = !wrap && (ph_inc == PH_W'(1));
    st.tab_stop_now   = (col_r != '0) && (ph_r == PH_W'(1));
    st.fill_last      = (cnt_r == CNT_W'(CELLS - 1));
    st.copy_last      = (cnt_r == CNT_W'(CELLS - COLUMNS));
    st.out_free       = !ovalid_r || out_tready;
  end

  // store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = blank;
    if (cmd.wr_char) begin
      wr_en   = 1'b1;
      wr_data = {text_attr, ch_r};
    end else if (cmd.wr_blank) begin
      wr_en = 1'b1;
    end else if (cmd.backspace) begin
      wr_en   = (col_r != '0);
      wr_addr = cur_addr - ADDR_W'(1);
    end else if (cmd.fill_step) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[ADDR_W-1:0];
      wr_data = cmd.fill_rst ? {ATTR_RESET, CH_SPACE} : blank;
    end else if (cmd.copy_step) begin
      wr_en   = (cnt_r != '0);
      wr_addr = cnt_r[ADDR_W-1:0] - ADDR_W'(1);
      wr_data = rd_data_r;
    end
  end

  // store read port, copy reads one row ahead
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cell_addr;
    if (cmd.read_cell) begin
      rd_en = 1'b1;
    end else if (cmd.copy_step && copy_rd) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(cnt_r + CNT_W'(COLUMNS));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_op;
      ch_r   <= in_ch;
      rrow_r <= in_row;
      rcol_r <= in_col;
    end
  end

  // cursor, flags and sweep counter
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    ph_nxt    = ph_r;
    bell_nxt  = bell_r;
    scr_nxt   = scr_r;
    cnt_nxt   = cnt_r;
    rd_ok_nxt = rd_ok_r;
    if (cmd.load_item) begin
      bell_nxt  = 1'b0;
      scr_nxt   = 1'b0;
      rd_ok_nxt = (in_op == OP_READ) && (in_row < ROWS) && (in_col < COLUMNS);
    end
    if (cmd.wr_char || cmd.wr_blank) begin
      if (wrap) begin
        col_nxt = '0;
        ph_nxt  = '0;
        row_nxt = at_bottom ? row_r : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
        ph_nxt  = ph_inc;
      end
    end
    if (cmd.new_line) begin
      col_nxt = '0;
      ph_nxt  = '0;
      row_nxt = at_bottom ? row_r : row_r + ROW_W'(1);
    end
    if (cmd.backspace && (col_r != '0)) begin
      col_nxt = col_r - COL_W'(1);
      ph_nxt  = ph_dec;
    end
    if (cmd.col_home || cmd.home) begin
      col_nxt = '0;
      ph_nxt  = '0;
    end
    if (cmd.home) begin
      row_nxt = '0;
    end
    if (cmd.set_bell) begin
      bell_nxt = 1'b1;
    end
    if (cmd.copy_step) begin
      scr_nxt = 1'b1;
    end
    if (cmd.fill_step || cmd.copy_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.sweep_clr) begin
      cnt_nxt = '0;
    end
    if (cmd.sweep_bot) begin
      cnt_nxt = CNT_W'(CELLS - COLUMNS);
    end
  end

  // result register
  assign o_char = rd_ok_r ? rd_data_r[7:0]  : 8'd0;
  assign o_attr = rd_ok_r ? rd_data_r[15:8] : 8'd0;

  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = {2'b00, scr_r, bell_r, 5'(row_r), 7'(col_r), o_attr, o_char};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      ph_r     <= '0;
      bell_r   <= 1'b0;
      scr_r    <= 1'b0;
      cnt_r    <= '0;
      rd_ok_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      ph_r     <= ph_nxt;
      bell_r   <= bell_nxt;
      scr_r    <= scr_nxt;
      cnt_r    <= cnt_nxt;
      rd_ok_r  <= rd_ok_nxt;
      ovalid_r <= ovalid_nxt;
    end
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

### rtl/core/tccw_ctrl.sv
`timescale 1ns / 1ps

module tccw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  tccw_pkg::status_t     st,
  output tccw_pkg::cmd_t        cmd
);
  import tccw_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_TAB   = 3'd3;
  localparam logic [2:0] S_SCP   = 3'd4;
  localparam logic [2:0] S_SBL   = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       tab_pend_r, tab_pend_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    tab_pend_nxt = tab_pend_r;
    cmd          = '0;
    case (state_r)
      // power-up blanking pass
      S_INIT: begin
        cmd.fill_step = 1'b1;
        cmd.fill_rst  = 1'b1;
        if (st.fill_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      // decode the operation
      S_EXEC: begin
        state_nxt = S_DONE;
        case (st.op)
          OP_PUT: begin
            case (st.ch)
              CH_BELL: cmd.set_bell  = 1'b1;
              CH_BS:   cmd.backspace = 1'b1;
              CH_CR:   cmd.col_home  = 1'b1;
              CH_TAB:  state_nxt     = S_TAB;
              CH_LF: begin
                cmd.new_line = 1'b1;
                if (st.at_bottom) begin
                  cmd.sweep_clr = 1'b1;
                  state_nxt     = S_SCP;
                end
              end
              default: begin
                cmd.wr_char = 1'b1;
                if (st.wrap && st.at_bottom) begin
                  cmd.sweep_clr = 1'b1;
                  state_nxt     = S_SCP;
                end
              end
            endcase
          end
          OP_CLEAR: begin
            cmd.home      = 1'b1;
            cmd.sweep_clr = 1'b1;
            state_nxt     = S_CLEAR;
          end
          OP_READ: cmd.read_cell = 1'b1;
          default: state_nxt = S_DONE;
        endcase
      end
      // one blank per cycle up to the next tab stop, paused while a scroll runs
      S_TAB: begin
        cmd.wr_blank = 1'b1;
        if (st.wrap && st.at_bottom) begin
          cmd.sweep_clr = 1'b1;
          tab_pend_nxt  = 1'b1;
          state_nxt     = S_SCP;
        end else if (st.tab_stop_after) begin
          state_nxt = S_DONE;
        end
      end
      // move every row up by one
      S_SCP: begin
        cmd.copy_step = 1'b1;
        if (st.copy_last) begin
          cmd.sweep_bot = 1'b1;
          state_nxt     = S_SBL;
        end
      end
      // blank the bottom row
      S_SBL: begin
        cmd.fill_step = 1'b1;
        if (st.fill_last) begin
          tab_pend_nxt = 1'b0;
          if (tab_pend_r && !st.tab_stop_now) begin
            state_nxt = S_TAB;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (st.fill_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      tab_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tab_pend_r <= tab_pend_nxt;
    end
  end

endmodule

### rtl/core/text_console_char_writer_unit.sv
`timescale 1ns / 1ps

// Text console writer for an 80x25 screen of character/attribute cells with
// a cursor. After reset the block blanks the whole screen store, one cell per
// cycle, and takes no transaction until done; register writes are taken
// throughout. Printable bytes, bell, backspace, carriage return, line feed
// and cell reads that need no scroll pass through accept, execute and result
// load; a tab adds a blank-write step for each blank written (one to four).
// A scroll runs through the single store write port one cell per cycle: a
// row copy followed by bottom-row blanking. A clear sweeps all 2000 cells.
// The result register lets the next transaction start while the last result
// is held.
module text_console_char_writer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,  // char_code, read_row, read_col, pad
  input  logic [1:0]                  in_tuser,  // operation
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // cell_char, cell_attr, cursor_col, cursor_row, bell, scrolled, pad
  output logic [31:0]                 out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tccw_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import tccw_pkg::*;

  cmd_t       cmd;
  status_t    st;
  logic [7:0] text_attr;

  tccw_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .text_attr   (text_attr)
  );

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tccw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .text_attr  (text_attr),
    .in_op      (in_tuser),
    .in_ch      (in_tdata[7:0]),
    .in_row     (in_tdata[12:8]),
    .in_col     (in_tdata[19:13]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // the blanking pass holds off input right after reset
  a_init_busy: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready during power-up blanking");

  // one transaction at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a transaction");

  // a scroll always leaves the cursor on the bottom row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[29]) |-> (out_tdata[27:23] == 5'(ROWS - 1)))
    else $error("scroll reported with cursor above bottom row");

  // bell never moves or scrolls the screen
  a_bell_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |-> !out_tdata[29])
    else $error("bell together with scroll");
`endif

endmodule
